@@ rtl/esc_pkg.sv @@
// Shared constants and helpers for the epoch-seconds to calendar converter.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package esc_pkg;

    // Field widths.
    localparam int SECS_W     = 31;
    localparam int DAYS_W     = 15;
    localparam int TOD_W      = 17;
    localparam int HOUR_W     = 5;
    localparam int MIN_W      = 6;
    localparam int SEC_W      = 6;
    localparam int DAY_W      = 5;
    localparam int MONTH_W    = 4;
    localparam int YEAR_W     = 11;
    localparam int DOY_W      = 9;

    // Registers from the input register to the result register, inclusive.
    localparam int PIPE_DEPTH = 8;

    // 86400 = 128 * 675. The day count is (secs >> 7) / 675, estimated with
    // floor(2^33 / 675) and corrected by one compare and subtract.
    localparam logic [23:0] DAY_RECIP      = 24'd12725829;
    localparam logic [9:0]  DAY_UNITS      = 10'd675;

    // 3600 = 16 * 225. ceil(2^24 / 225) is exact for (tod >> 4) < 5400.
    localparam logic [16:0] HOUR_RECIP     = 17'd74566;
    localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;

    // 60 = 4 * 15. ceil(2^14 / 15) is exact for (rem >> 2) < 900.
    localparam logic [10:0] MIN_RECIP      = 11'd1093;
    localparam logic [5:0]  SECS_PER_MIN   = 6'd60;

    // Four-year cycles counted from 1969-01-01. ceil(2^25 / 1461) is exact
    // for every shifted day count this block can see.
    localparam logic [14:0] CYCLE_RECIP    = 15'd22967;
    localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;
    localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
    localparam logic [10:0] BASE_YEAR      = 11'd1969;

    // First day of each month (0-based day of year) in a common year.
    localparam logic [DOY_W-1:0] MONTH_START [12] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // First day of month idx (0 = January), one later from March on in a leap year.
    function automatic logic [DOY_W-1:0] month_start(input logic [3:0] idx,
                                                     input logic leap);
        logic [DOY_W-1:0] base;
        base = MONTH_START[idx];
        if (leap && idx >= 4'd2) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

`default_nettype wire

@@ rtl/esc_time_split.sv @@
// Time-of-day datapath: splits seconds into whole days, hour, minute, second.
// Depends on esc_pkg. Days leave after two stages, the time fields after seven.
`default_nettype none

module esc_time_split import esc_pkg::*; (
    input  logic              i_clk,
    input  logic [SECS_W-1:0] i_secs,
    output logic [DAYS_W-1:0] o_days,
    output logic [HOUR_W-1:0] o_hour,
    output logic [MIN_W-1:0]  o_minute,
    output logic [SEC_W-1:0]  o_second
);

    // Stage 1: day count estimate.
    logic [47:0]        n_day_prod;
    logic [DAYS_W-1:0]  r_day_est;
    logic [SECS_W-1:0]  r_secs1;

    // Stage 2: correction and time of day.
    logic [23:0]        n_day_base;
    logic [23:0]        n_rem_full;
    logic               n_day_fix;
    logic [9:0]         n_rem_lo;
    logic [DAYS_W-1:0]  r_days;
    logic [TOD_W-1:0]   r_tod;

    // Stages 3 to 7.
    logic [29:0]        n_hour_prod;
    logic [HOUR_W-1:0]  r_hour3, r_hour4, r_hour5, r_hour6, r_hour7;
    logic [TOD_W-1:0]   r_tod3;
    logic [16:0]        n_hour_base;
    logic [16:0]        n_remh_full;
    logic [11:0]        r_remh4, r_remh5;
    logic [20:0]        n_min_prod;
    logic [MIN_W-1:0]   r_min5, r_min6, r_min7;
    logic [11:0]        n_min_base;
    logic [11:0]        n_sec_full;
    logic [SEC_W-1:0]   r_sec6, r_sec7;

    assign n_day_prod  = 48'(i_secs[30:7]) * 48'(DAY_RECIP);

    assign n_day_base  = 24'(r_day_est) * 24'(DAY_UNITS);
    assign n_rem_full  = r_secs1[30:7] - n_day_base;
    // The estimate is low by at most one day.
    assign n_day_fix   = (n_rem_full[10:0] >= {1'b0, DAY_UNITS});
    assign n_rem_lo    = n_day_fix ? (n_rem_full[9:0] - DAY_UNITS) : n_rem_full[9:0];

    assign n_hour_prod = 30'(r_tod[16:4]) * 30'(HOUR_RECIP);
    assign n_hour_base = 17'(r_hour3) * 17'(SECS_PER_HOUR);
    assign n_remh_full = r_tod3 - n_hour_base;
    assign n_min_prod  = 21'(r_remh4[11:2]) * 21'(MIN_RECIP);
    assign n_min_base  = 12'(r_min5) * 12'(SECS_PER_MIN);
    assign n_sec_full  = r_remh5 - n_min_base;

    always_ff @(posedge i_clk) begin
        r_day_est <= n_day_prod[47:33];
        r_secs1   <= i_secs;

        r_days    <= r_day_est + DAYS_W'(n_day_fix);
        r_tod     <= {n_rem_lo, r_secs1[6:0]};

        r_hour3   <= n_hour_prod[28:24];
        r_tod3    <= r_tod;

        r_remh4   <= n_remh_full[11:0];
        r_hour4   <= r_hour3;

        r_min5    <= n_min_prod[19:14];
        r_remh5   <= r_remh4;
        r_hour5   <= r_hour4;

        r_sec6    <= n_sec_full[5:0];
        r_min6    <= r_min5;
        r_hour6   <= r_hour5;

        r_sec7    <= r_sec6;
        r_min7    <= r_min6;
        r_hour7   <= r_hour6;
    end

    assign o_days   = r_days;
    assign o_hour   = r_hour7;
    assign o_minute = r_min7;
    assign o_second = r_sec7;

endmodule

`default_nettype wire

@@ rtl/esc_date_split.sv @@
// Date datapath: turns a day count since 1970-01-01 into year, month and day.
// Depends on esc_pkg. Takes the stage-two day count, delivers at stage seven.
`default_nettype none

module esc_date_split import esc_pkg::*; (
    input  logic               i_clk,
    input  logic [DAYS_W-1:0]  i_days,
    output logic [YEAR_W-1:0]  o_year,
    output logic [MONTH_W-1:0] o_month,
    output logic [DAY_W-1:0]   o_day
);

    // Within 1970..2038 the only century year is 2000, which is a leap year,
    // so every fourth year from 1972 is a leap year. Days are counted from
    // 1969-01-01 so that each four-year cycle ends with its leap year.
    logic [DAYS_W-1:0]  n_shift;
    logic [29:0]        n_cyc_prod;
    logic [4:0]         r_cyc3, r_cyc4, r_cyc5;
    logic [DAYS_W-1:0]  r_shift3;
    logic [14:0]        n_cyc_base;
    logic [14:0]        n_rc_full;
    logic [10:0]        r_rc4;
    logic [1:0]         n_yc;
    logic [10:0]        n_yr_base;
    logic [10:0]        n_doy_full;
    logic [DOY_W-1:0]   r_doy5, r_doy6;
    logic               r_leap5;
    logic [1:0]         r_yc5;
    logic [3:0]         n_month_idx;
    logic [DOY_W-1:0]   n_mstart;
    logic [MONTH_W-1:0] r_month6, r_month7;
    logic [DOY_W-1:0]   r_mstart6;
    logic [YEAR_W-1:0]  r_year6, r_year7;
    logic [DOY_W-1:0]   n_day_full;
    logic [DAY_W-1:0]   r_day7;

    assign n_shift    = i_days + DAYS_W'(DAYS_PER_YEAR);
    assign n_cyc_prod = 30'(n_shift) * 30'(CYCLE_RECIP);
    assign n_cyc_base = 15'(r_cyc3) * 15'(DAYS_PER_CYCLE);
    assign n_rc_full  = r_shift3 - n_cyc_base;

    always_comb begin
        if (r_rc4 >= 11'(3 * DAYS_PER_YEAR)) begin
            n_yc = 2'd3;
        end else if (r_rc4 >= 11'(2 * DAYS_PER_YEAR)) begin
            n_yc = 2'd2;
        end else if (r_rc4 >= 11'(DAYS_PER_YEAR)) begin
            n_yc = 2'd1;
        end else begin
            n_yc = 2'd0;
        end
        case (n_yc)
            2'd0:    n_yr_base = '0;
            2'd1:    n_yr_base = 11'(DAYS_PER_YEAR);
            2'd2:    n_yr_base = 11'(2 * DAYS_PER_YEAR);
            default: n_yr_base = 11'(3 * DAYS_PER_YEAR);
        endcase
        n_doy_full = r_rc4 - n_yr_base;
    end

    // The month is the last one whose first day is not after the day of year.
    always_comb begin
        n_month_idx = '0;
        n_mstart    = '0;
        for (int m = 0; m < 12; m++) begin
            if (r_doy5 >= month_start(4'(m), r_leap5)) begin
                n_month_idx = 4'(m);
                n_mstart    = month_start(4'(m), r_leap5);
            end
        end
    end

    assign n_day_full = r_doy6 - r_mstart6 + 9'd1;

    always_ff @(posedge i_clk) begin
        r_cyc3    <= n_cyc_prod[29:25];
        r_shift3  <= n_shift;

        r_rc4     <= n_rc_full[10:0];
        r_cyc4    <= r_cyc3;

        r_doy5    <= n_doy_full[8:0];
        r_leap5   <= (n_yc == 2'd3);
        r_yc5     <= n_yc;
        r_cyc5    <= r_cyc4;

        r_month6  <= n_month_idx + 4'd1;
        r_mstart6 <= n_mstart;
        r_doy6    <= r_doy5;
        r_year6   <= BASE_YEAR + YEAR_W'({r_cyc5, 2'b00}) + YEAR_W'(r_yc5);

        r_day7    <= n_day_full[4:0];
        r_month7  <= r_month6;
        r_year7   <= r_year6;
    end

    assign o_year  = r_year7;
    assign o_month = r_month7;
    assign o_day   = r_day7;

endmodule

`default_nettype wire

@@ rtl/epoch_seconds_to_calendar.sv @@
// Top level of the epoch-seconds to calendar converter.
// Depends on esc_pkg, esc_time_split and esc_date_split.
//
//   channel   handshake          payload
//   input     start / busy       i_epoch_seconds
//   result    o_valid (strobe)   o_hour_of_day, o_minute_of_hour, o_second_of_minute,
//                                o_day_of_month, o_month_number, o_year_number
//
// One item is taken every cycle; busy is always low.
// The result strobe is a valid bit shifted along beside the item, so it rises together
// with the result; the depth is set by the pipelined reciprocal multiplies for the
// day, hour, minute and four-year cycle splits.
// Reset clears the valid bits of the pipeline, so items in flight are dropped.
// The receiver cannot stall; results are shown for exactly one cycle.
`default_nettype none

module epoch_seconds_to_calendar import esc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [SECS_W-1:0]  i_epoch_seconds,
    output logic               o_valid,
    output logic [HOUR_W-1:0]  o_hour_of_day,
    output logic [MIN_W-1:0]   o_minute_of_hour,
    output logic [SEC_W-1:0]   o_second_of_minute,
    output logic [DAY_W-1:0]   o_day_of_month,
    output logic [MONTH_W-1:0] o_month_number,
    output logic [YEAR_W-1:0]  o_year_number
);

    logic                  n_accept;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] n_vld;
    logic [SECS_W-1:0]     r_secs;
    logic [DAYS_W-1:0]     w_days;

    assign busy     = 1'b0;
    assign n_accept = start && !busy;
    assign n_vld    = {r_vld[PIPE_DEPTH-2:0], n_accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_secs <= i_epoch_seconds;
        end
    end

    esc_time_split u_time (
        .i_clk    (i_clk),
        .i_secs   (r_secs),
        .o_days   (w_days),
        .o_hour   (o_hour_of_day),
        .o_minute (o_minute_of_hour),
        .o_second (o_second_of_minute)
    );

    esc_date_split u_date (
        .i_clk   (i_clk),
        .i_days  (w_days),
        .o_year  (o_year_number),
        .o_month (o_month_number),
        .o_day   (o_day_of_month)
    );

    assign o_valid = r_vld[PIPE_DEPTH-1];

endmodule

`default_nettype wire

@@ rtl/esc_checker.sv @@
// Port-level checks for the epoch-seconds to calendar converter.
// Depends on esc_pkg; bound to epoch_seconds_to_calendar at the end of the file.
`default_nettype none

module esc_checker import esc_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic [HOUR_W-1:0]  o_hour_of_day,
    input logic [MIN_W-1:0]   o_minute_of_hour,
    input logic [SEC_W-1:0]   o_second_of_minute,
    input logic [DAY_W-1:0]   o_day_of_month,
    input logic [MONTH_W-1:0] o_month_number,
    input logic [YEAR_W-1:0]  o_year_number
);

    // Every accepted item comes out exactly once, a fixed time later.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##PIPE_DEPTH o_valid)
        else $error("accepted item produced no result");

    a_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PIPE_DEPTH))
        else $error("result without a matching accepted item");

    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hour_of_day <= 5'd23 && o_minute_of_hour <= 6'd59
            && o_second_of_minute <= 6'd59 && o_day_of_month >= 5'd1
            && o_month_number >= 4'd1 && o_month_number <= 4'd12
            && o_year_number >= 11'd1970 && o_year_number <= 11'd2038)
        else $error("result field out of range");

    a_short_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_month_number == 4'd2 || o_month_number == 4'd4
            || o_month_number == 4'd6 || o_month_number == 4'd9
            || o_month_number == 4'd11) |-> o_day_of_month <= 5'd30
            && (o_month_number != 4'd2 || o_day_of_month <= 5'd29))
        else $error("day past the end of a short month");

    a_leap_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_month_number == 4'd2 && o_day_of_month == 5'd29
            |-> o_year_number[1:0] == 2'b00)
        else $error("February 29 in a common year");

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (.*);

`default_nettype wire
